### design/vkt_pkg.sv
// shared types and constants for the versioned key table
`default_nettype none
package vkt_pkg;
  localparam int TABLE_DEPTH = 16;
  localparam int KEY_CHARS   = 3;
  localparam int KEY_W       = 8 * KEY_CHARS;
  localparam int VER_W       = 16;
  localparam int VAL_W       = 31;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int TSIZE_W     = 5;

  localparam logic [2:0] MODE_INSERT   = 3'd0;
  localparam logic [2:0] MODE_FIND_KEY = 3'd1;
  localparam logic [2:0] MODE_FIND_VER = 3'd2;
  localparam logic [2:0] MODE_DEL_KEY  = 3'd3;
  localparam logic [2:0] MODE_DEL_VER  = 3'd4;
  localparam logic [2:0] MODE_COMPRESS = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [2:0]       mode;
    logic [KEY_W-1:0] key;
    logic [VER_W-1:0] version;
    logic [VAL_W-1:0] value_a;
    logic [VAL_W-1:0] value_b;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [KEY_W-1:0] found_key;
    logic [VER_W-1:0] found_version;
    logic [VAL_W-1:0] found_value_a;
    logic [VAL_W-1:0] found_value_b;
    logic             last;
  } rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VER_W-1:0] version;
    logic [VAL_W-1:0] value_a;
    logic [VAL_W-1:0] value_b;
  } entry_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_INS_RD, S_INS_CHK, S_INS_WR,
    S_FND_RD, S_FND_CHK, S_FND_END,
    S_DEL_RD, S_DEL_CHK, S_DEL_MOVE,
    S_CMP_KEY_RD, S_CMP_KEY, S_CMP_MAX_RD, S_CMP_MAX, S_CMP_SCN_RD, S_CMP_SCN
  } state_t;
endpackage
`default_nettype wire

### design/vkt_mem.sv
// entry store: one write port, one registered read port
`default_nettype none
module vkt_mem (
  input  wire                        clk,
  input  wire                        we,
  input  wire  [vkt_pkg::IDX_W-1:0]  waddr,
  input  vkt_pkg::entry_t            wdata,
  input  wire  [vkt_pkg::IDX_W-1:0]  raddr,
  output vkt_pkg::entry_t            rdata
);
  import vkt_pkg::*;

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### design/versioned_key_table_core.sv
// versioned key table: sequencer around a single entry memory
//
//  channel   signals                  handshake
//  request   start, busy, req         taken when start & !busy
//  result    rsp_valid, rsp           one cycle per result, no stall
//  config    cfg_we, cfg_wdata        written when cfg_we
//
// every entry visit is a read-issue state followed by a compare state, because
// the memory read port is registered. a delete adds a move state per removed
// entry; compress repeats key, max and scan passes until a key pass ends with
// no change.
// reset clears the entry count and sets table_size to 16; no clearing pass.
// results cannot be held off by the receiver.
`default_nettype none
module versioned_key_table_core (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  output logic                         busy,
  input  vkt_pkg::req_t                req,
  input  wire                          cfg_we,
  input  wire  [vkt_pkg::TSIZE_W-1:0]  cfg_wdata,
  output logic                         rsp_valid,
  output vkt_pkg::rsp_t                rsp
);
  import vkt_pkg::*;

  state_t state, state_next;
  req_t   op, op_next;
  logic [TSIZE_W-1:0] tsize;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] ci, ci_next;
  logic [CNT_W-1:0] cj, cj_next;
  logic [KEY_W-1:0] ck, ck_next;
  logic [VER_W-1:0] ctop, ctop_next;
  logic [VER_W-1:0] dver, dver_next;
  logic             is_cmp, is_cmp_next;
  logic             changed, changed_next;
  logic             any, any_next;
  logic             seen, seen_next;
  logic [VER_W-1:0] top, top_next;
  logic             pend_valid, pend_valid_next;
  entry_t           pend, pend_next;
  logic             rsp_valid_next;
  rsp_t             rsp_next;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  entry_t           mem_wdata, rdata;

  logic             full, del_match, del_use_ver;
  logic [KEY_W-1:0] del_key;
  logic [VER_W-1:0] new_ver;
  logic [CNT_W-1:0] cnt_m1;

  vkt_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  assign busy   = (state != S_IDLE);
  assign cnt_m1 = cnt - CNT_W'(1);
  assign full   = (cnt >= CNT_W'(TABLE_DEPTH)) || (32'(cnt) >= 32'(tsize));
  assign new_ver = !seen ? '0 : ((&top) ? top : top + VER_W'(1));
  assign del_key     = is_cmp ? ck : op.key;
  assign del_use_ver = is_cmp || (op.mode == MODE_DEL_VER);
  assign del_match   = (rdata.key == del_key) && (!del_use_ver || rdata.version == dver);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (req.mode)
            MODE_INSERT:   state_next = full ? S_IDLE : S_INS_RD;
            MODE_FIND_KEY,
            MODE_FIND_VER: state_next = S_FND_RD;
            MODE_DEL_KEY,
            MODE_DEL_VER:  state_next = S_DEL_RD;
            MODE_COMPRESS: state_next = S_CMP_KEY_RD;
            default:       state_next = S_IDLE;
          endcase
        end
      end
      S_INS_RD:   state_next = (idx < cnt) ? S_INS_CHK : S_INS_WR;
      S_INS_CHK:  state_next = S_INS_RD;
      S_INS_WR:   state_next = S_IDLE;
      S_FND_RD:   state_next = (idx < cnt) ? S_FND_CHK : S_FND_END;
      S_FND_CHK:  state_next = S_FND_RD;
      S_FND_END:  state_next = S_IDLE;
      S_DEL_RD: begin
        if (idx < cnt) state_next = S_DEL_CHK;
        else state_next = is_cmp ? S_CMP_SCN_RD : S_IDLE;
      end
      S_DEL_CHK:  state_next = del_match ? S_DEL_MOVE : S_DEL_RD;
      S_DEL_MOVE: state_next = S_DEL_RD;
      S_CMP_KEY_RD: begin
        if (ci < cnt) state_next = S_CMP_KEY;
        else state_next = changed ? S_CMP_KEY_RD : S_IDLE;
      end
      S_CMP_KEY:    state_next = S_CMP_MAX_RD;
      S_CMP_MAX_RD: state_next = (idx < cnt) ? S_CMP_MAX : S_CMP_SCN_RD;
      S_CMP_MAX:    state_next = S_CMP_MAX_RD;
      S_CMP_SCN_RD: state_next = (cj < cnt) ? S_CMP_SCN : S_CMP_KEY_RD;
      S_CMP_SCN: begin
        if (rdata.key == ck && rdata.version < ctop) state_next = S_DEL_RD;
        else state_next = S_CMP_SCN_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    op_next         = op;
    cnt_next        = cnt;
    idx_next        = idx;
    ci_next         = ci;
    cj_next         = cj;
    ck_next         = ck;
    ctop_next       = ctop;
    dver_next       = dver;
    is_cmp_next     = is_cmp;
    changed_next    = changed;
    any_next        = any;
    seen_next       = seen;
    top_next        = top;
    pend_valid_next = pend_valid;
    pend_next       = pend;
    rsp_valid_next  = 1'b0;
    rsp_next        = '0;
    rsp_next.last   = 1'b1;
    mem_we          = 1'b0;
    mem_waddr       = idx[IDX_W-1:0];
    mem_wdata       = rdata;
    mem_raddr       = idx[IDX_W-1:0];
    case (state)
      S_IDLE: begin
        if (start) begin
          op_next         = req;
          idx_next        = '0;
          ci_next         = '0;
          seen_next       = 1'b0;
          top_next        = '0;
          any_next        = 1'b0;
          changed_next    = 1'b0;
          pend_valid_next = 1'b0;
          dver_next       = req.version;
          is_cmp_next     = (req.mode == MODE_COMPRESS);
          case (req.mode)
            MODE_INSERT: begin
              if (full) begin
                rsp_valid_next  = 1'b1;
                rsp_next.status = ST_FULL;
              end
            end
            MODE_FIND_KEY, MODE_FIND_VER, MODE_DEL_KEY, MODE_DEL_VER,
            MODE_COMPRESS: ;
            default: begin
              rsp_valid_next = 1'b1;
            end
          endcase
        end
      end
      S_INS_CHK: begin
        if (rdata.key == op.key && (!seen || rdata.version > top)) begin
          top_next  = rdata.version;
          seen_next = 1'b1;
        end
        idx_next = idx + CNT_W'(1);
      end
      S_INS_WR: begin
        mem_we                 = 1'b1;
        mem_waddr              = cnt[IDX_W-1:0];
        mem_wdata.key          = op.key;
        mem_wdata.version      = new_ver;
        mem_wdata.value_a      = op.value_a;
        mem_wdata.value_b      = op.value_b;
        cnt_next               = cnt + CNT_W'(1);
        rsp_valid_next         = 1'b1;
        rsp_next.found_key     = op.key;
        rsp_next.found_version = new_ver;
        rsp_next.found_value_a = op.value_a;
        rsp_next.found_value_b = op.value_b;
      end
      S_FND_CHK: begin
        if (rdata.key == op.key &&
            (op.mode == MODE_FIND_KEY || rdata.version == op.version)) begin
          // hold each match back until the next one so the final one can carry last
          if (pend_valid) begin
            rsp_valid_next         = 1'b1;
            rsp_next.last          = 1'b0;
            rsp_next.found_key     = pend.key;
            rsp_next.found_version = pend.version;
            rsp_next.found_value_a = pend.value_a;
            rsp_next.found_value_b = pend.value_b;
          end
          pend_valid_next = 1'b1;
          pend_next       = rdata;
        end
        idx_next = idx + CNT_W'(1);
      end
      S_FND_END: begin
        rsp_valid_next = 1'b1;
        if (pend_valid) begin
          rsp_next.found_key     = pend.key;
          rsp_next.found_version = pend.version;
          rsp_next.found_value_a = pend.value_a;
          rsp_next.found_value_b = pend.value_b;
        end else begin
          rsp_next.status = ST_NOT_FOUND;
        end
      end
      S_DEL_RD: begin
        if (!(idx < cnt) && !is_cmp) begin
          rsp_valid_next  = 1'b1;
          rsp_next.status = any ? ST_OK : ST_NOT_FOUND;
        end
      end
      S_DEL_CHK: begin
        // on a hit fetch the last entry to fill the hole; recheck same slot
        if (del_match) mem_raddr = cnt_m1[IDX_W-1:0];
        else idx_next = idx + CNT_W'(1);
      end
      S_DEL_MOVE: begin
        mem_we    = 1'b1;
        mem_wdata = rdata;
        cnt_next  = cnt_m1;
        any_next  = 1'b1;
      end
      S_CMP_KEY_RD: begin
        mem_raddr = ci[IDX_W-1:0];
        if (!(ci < cnt)) begin
          if (changed) begin
            ci_next      = '0;
            changed_next = 1'b0;
          end else begin
            rsp_valid_next = 1'b1;
          end
        end
      end
      S_CMP_KEY: begin
        ck_next   = rdata.key;
        ctop_next = rdata.version;
        idx_next  = '0;
      end
      S_CMP_MAX_RD: begin
        if (!(idx < cnt)) cj_next = '0;
      end
      S_CMP_MAX: begin
        if (rdata.key == ck && rdata.version > ctop) ctop_next = rdata.version;
        idx_next = idx + CNT_W'(1);
      end
      S_CMP_SCN_RD: begin
        mem_raddr = cj[IDX_W-1:0];
        if (!(cj < cnt)) ci_next = ci + CNT_W'(1);
      end
      S_CMP_SCN: begin
        // older version found: strip all copies of it, holes lie at or past cj
        if (rdata.key == ck && rdata.version < ctop) begin
          dver_next    = rdata.version;
          idx_next     = cj;
          changed_next = 1'b1;
        end else begin
          cj_next = cj + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      tsize      <= TSIZE_W'(16);
      rsp_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      rsp_valid  <= rsp_valid_next;
      pend_valid <= pend_valid_next;
      if (cfg_we) tsize <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    op      <= op_next;
    idx     <= idx_next;
    ci      <= ci_next;
    cj      <= cj_next;
    ck      <= ck_next;
    ctop    <= ctop_next;
    dver    <= dver_next;
    is_cmp  <= is_cmp_next;
    changed <= changed_next;
    any     <= any_next;
    seen    <= seen_next;
    top     <= top_next;
    pend    <= pend_next;
    rsp     <= rsp_next;
  end
endmodule
`default_nettype wire

### design/vkt_checker.sv
// port-level checks for the versioned key table, bound to the top level
`default_nettype none
module vkt_checker (
  input wire           clk,
  input wire           rst,
  input wire           start,
  input wire           busy,
  input wire           rsp_valid,
  input vkt_pkg::rsp_t rsp
);
  import vkt_pkg::*;

  // busy only goes high right after a request is taken
  a_busy_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");

  // the final result goes out as busy drops
  a_fell_result: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> (rsp_valid && rsp.last))
    else $error("operation ended without a final result");

  // a result that is not the last one comes while the operation runs
  a_more_pending: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.last) |-> busy)
    else $error("non-final result outside an operation");

  // error results carry no entry
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != ST_OK) |->
      (rsp.found_key == '0 && rsp.found_version == '0 && rsp.last))
    else $error("error result with entry data");
endmodule

bind versioned_key_table_core vkt_checker u_vkt_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .rsp_valid (rsp_valid),
  .rsp       (rsp)
);
`default_nettype wire
